// ===== rtl/core/tdfs_pkg.sv =====
// shared types and constants of the timer divider factor search
`default_nettype none

package tdfs_pkg;

   localparam int IN_W = 30;
   localparam int OUT_W = 16;
   localparam int NUM_W = 32;
   localparam int DEN_W = 32;
   localparam int DIV_STEPS = 2;
   localparam int COUNTER_WIDTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ZERO  = 2'd1,
      ST_LARGE = 2'd2
   } status_type;

   typedef struct packed {
      logic [IN_W-1:0] core_clock_hz;
      logic [IN_W-1:0] bus_clock_hz;
      logic [IN_W-1:0] sample_rate_hz;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [OUT_W-1:0] prescale_value;
      logic [OUT_W-1:0] period_value;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [NUM_W-1:0] quo;
      logic [DEN_W-1:0] rem;
   } div_res_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_CLK,
      S_RANGE,
      S_DIV_START,
      S_TRIAL,
      S_DIV_OTHER,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/tdfs_divider.sv =====
// serial restoring divider, two quotient bits per cycle
`default_nettype none

module tdfs_divider
   import tdfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_cmd_type cmd,
   output div_res_type      res
);

   localparam int CYCLES = NUM_W / DIV_STEPS;
   localparam int CNT_W = $clog2(CYCLES + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   always_comb begin
      logic [DEN_W:0] wide;
      logic [DEN_W-1:0] acc;
      logic [NUM_W-1:0] num;
      acc = rem_ff;
      num = num_ff;
      wide = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         wide = {acc, num[NUM_W-1]};
         num = {num[NUM_W-2:0], 1'b0};
         if (wide >= {1'b0, den_ff}) begin
            wide = wide - {1'b0, den_ff};
            num[0] = 1'b1;
         end
         acc = wide[DEN_W-1:0];
      end
      rem_in = acc;
      num_in = num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CNT_W'(CYCLES);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         num_ff <= cmd.numer;
         den_ff <= cmd.denom;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign res.busy = busy_ff;
   assign res.done = done_ff;
   assign res.quo = num_ff;
   assign res.rem = rem_ff;

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

endmodule

`default_nettype wire

// ===== rtl/core/timer_divider_factor_search.sv =====
// Timer divider factor search: prescaler and period for a wanted trigger rate.
// One request beat on req_ carries the core clock, bus clock and sample rate.
// One response beat on rsp_ carries status, prescale_value and period_value.
// Requests are taken only while no search is running (req_stall high during
// a search). The result sits in an output register; a new request may be
// taken while it waits, and the search stalls at its end until the register
// frees up.
// Every division runs on one shared serial divider, two quotient bits per
// cycle.
// A zero rate needs no division; one division suffices when the divisor fits
// the counter; otherwise, unless the ratio is too large, a factor search runs
// with up to 2^COUNTER_WIDTH - 2 trials. The divider sets the pace.
// Reset is synchronous and clears the controller and the output valid; any
// search in progress is dropped.
// A stalled response holds its data until taken.
`default_nettype none

module timer_divider_factor_search
   import tdfs_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam logic [DEN_W-1:0] CMAX = DEN_W'((64'd1 << COUNTER_WIDTH) - 64'd1);
   localparam logic [COUNTER_WIDTH-1:0] CMAX_CW = CMAX[COUNTER_WIDTH-1:0];

   state_type state_ff, state_in;

   logic [NUM_W-1:0]         div_ff, div_in;
   logic [COUNTER_WIDTH-1:0] r_ff, r_in;
   logic [COUNTER_WIDTH-1:0] best_r_ff, best_r_in;
   logic [COUNTER_WIDTH-1:0] best_rem_ff, best_rem_in;
   rsp_type                  res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   div_cmd_type div_cmd;
   div_res_type div_res;

   logic                     accept;
   logic                     out_free;
   logic [NUM_W-1:0]         tclk;
   logic [COUNTER_WIDTH-1:0] rem_lo;
   logic                     better;
   logic [COUNTER_WIDTH-1:0] nb_r;
   logic                     search_end;
   logic [DEN_W-1:0]         br_wide;
   logic [NUM_W-1:0]         other_m1;
   logic [DEN_W-1:0]         br_m1;
   logic [NUM_W-1:0]         div_m1;

   tdfs_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign tclk = (req_data.core_clock_hz == req_data.bus_clock_hz)
      ? NUM_W'(req_data.bus_clock_hz) : NUM_W'({req_data.bus_clock_hz, 1'b0});

   assign rem_lo = div_res.rem[COUNTER_WIDTH-1:0];
   assign better = rem_lo < best_rem_ff;
   assign nb_r = better ? r_ff : best_r_ff;
   assign search_end = (rem_lo == '0) || (r_ff == CMAX_CW);
   assign br_wide = DEN_W'(best_r_ff);
   assign other_m1 = div_res.quo - NUM_W'(1);
   assign br_m1 = br_wide - DEN_W'(1);
   assign div_m1 = div_ff - NUM_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_data.sample_rate_hz == '0) ? S_DONE : S_DIV_CLK;
            end
         end
         S_DIV_CLK: begin
            if (div_res.done) begin
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            if ((div_ff == '0) || (div_ff <= NUM_W'(CMAX))) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DIV_START;
            end
         end
         S_DIV_START: begin
            if (div_res.done) begin
               state_in = (div_res.quo >= NUM_W'(CMAX)) ? S_DONE : S_TRIAL;
            end
         end
         S_TRIAL: begin
            if (div_res.done && search_end) begin
               state_in = S_DIV_OTHER;
            end
         end
         S_DIV_OTHER: begin
            if (div_res.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      div_cmd.start = 1'b0;
      div_cmd.numer = div_ff;
      div_cmd.denom = '0;
      div_in = div_ff;
      r_in = r_ff;
      best_r_in = best_r_ff;
      best_rem_in = best_rem_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            res_in.status = ST_ZERO;
            res_in.prescale_value = '0;
            res_in.period_value = '0;
            if (accept && (req_data.sample_rate_hz != '0)) begin
               div_cmd.start = 1'b1;
               div_cmd.numer = tclk;
               div_cmd.denom = DEN_W'(req_data.sample_rate_hz);
            end
         end
         S_DIV_CLK: begin
            if (div_res.done) begin
               div_in = div_res.quo;
            end
         end
         S_RANGE: begin
            if (div_ff == '0) begin
               res_in.status = ST_ZERO;
            end else if (div_ff <= NUM_W'(CMAX)) begin
               res_in.status = ST_OK;
               res_in.period_value = div_m1[OUT_W-1:0];
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.denom = CMAX;
            end
         end
         S_DIV_START: begin
            if (div_res.done) begin
               if (div_res.quo >= NUM_W'(CMAX)) begin
                  res_in.status = ST_LARGE;
               end else begin
                  r_in = div_res.quo[COUNTER_WIDTH-1:0] + COUNTER_WIDTH'(1);
                  best_r_in = r_in;
                  best_rem_in = '1;
                  div_cmd.start = 1'b1;
                  div_cmd.denom = DEN_W'(r_in);
               end
            end
         end
         S_TRIAL: begin
            if (div_res.done) begin
               best_r_in = nb_r;
               if (better) begin
                  best_rem_in = rem_lo;
               end
               div_cmd.start = 1'b1;
               if (search_end) begin
                  div_cmd.denom = DEN_W'(nb_r);
               end else begin
                  r_in = r_ff + COUNTER_WIDTH'(1);
                  div_cmd.denom = DEN_W'(r_in);
               end
            end
         end
         S_DIV_OTHER: begin
            if (div_res.done) begin
               res_in.status = ST_OK;
               if (NUM_W'(br_wide) > div_res.quo) begin
                  res_in.prescale_value = other_m1[OUT_W-1:0];
                  res_in.period_value = br_m1[OUT_W-1:0];
               end else begin
                  res_in.prescale_value = br_m1[OUT_W-1:0];
                  res_in.period_value = other_m1[OUT_W-1:0];
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      r_ff <= r_in;
      best_r_ff <= best_r_in;
      best_rem_ff <= best_rem_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_accept_next : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_DONE) || (state_ff == S_DIV_CLK))
      else $error("accepted beat did not start work");

   a_search_stop : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_OTHER) |-> (best_rem_ff == '0) || (r_ff == CMAX_CW))
      else $error("factor search ended early");

   a_best_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_OTHER) |-> (best_r_ff <= r_ff))
      else $error("best ratio beyond tried range");

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != ST_OK))
         |-> (rsp_data_ff.prescale_value == '0) && (rsp_data_ff.period_value == '0))
      else $error("error response with nonzero values");

endmodule

`default_nettype wire
